// ===== hw/rtl/tpbrd_pkg.sv =====
`timescale 1ns / 1ps

package tpbrd_pkg;

  // A store write clears the store once it holds more than this many entries
  localparam logic [31:0] CLEAR_LIMIT = 32'd500;
  // CORDIC gain compensation, 0.6072529 in Q30
  localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
  localparam int ATAN_IDX_W = 5;

  // Stored entry: stamp, position and 16-bit binary yaw
  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        yaw;
  } tpbrd_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap;
    logic sq;
    logic vec_ld;
    logic wr;
    logic scan;
    logic rd_start;
    logic rd_end;
    logic lat_start;
    logic lat_end;
    logic rot1_ld;
    logic cs_cap;
    logic mul;
    logic rot2_ld;
    logic out_load;
  } tpbrd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_query;
    logic cordic_busy;
    logic scan_done;
    logic found_both;
    logic mul_done;
    logic out_free;
  } tpbrd_sts_t;

  // atan(2^-i) in 32-bit binary angle units
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Saturate to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q30 to Q14, round to nearest, clamp to one
  function automatic logic [15:0] q30_to_q14(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [19:0] s;
    logic [15:0]        r;
    t = v + 36'sd32768;
    s = t[35:16];
    if (s > 20'sd16384) begin
      r = 16'h4000;
    end else if (s < -20'sd16384) begin
      r = 16'hC000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tpbrd_cordic.sv =====
`timescale 1ns / 1ps

module tpbrd_cordic
  import tpbrd_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               vec_mode,
  input  logic signed [35:0] x0,
  input  logic signed [35:0] y0,
  input  logic signed [33:0] z0,
  output logic               busy,
  output logic signed [35:0] x,
  output logic signed [35:0] y,
  output logic signed [33:0] z
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);

  logic               busy_r;
  logic               mode_r;
  logic [STEP_W-1:0]  step_r;
  logic signed [35:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic signed [35:0] xs, ys;
  logic signed [33:0] at;
  logic               pos;

  // One micro-rotation per cycle
  always_comb begin
    xs  = x_r >>> step_r;
    ys  = y_r >>> step_r;
    at  = 34'(atan_turn(ATAN_IDX_W'(step_r)));
    pos = mode_r ? !(y_r > 36'sd0) : !z_r[33];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= vec_mode;
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
    end else if (busy_r) begin
      x_r <= pos ? x_r - ys : x_r + ys;
      y_r <= pos ? y_r + xs : y_r - xs;
      z_r <= pos ? z_r - at : z_r + at;
    end
  end

  assign busy = busy_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

// ===== hw/rtl/tpbrd_dp.sv =====
`timescale 1ns / 1ps

module tpbrd_dp
  import tpbrd_pkg::*;
#(
  parameter int DEPTH        = 512,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpbrd_cmd_t         cmd,
  output tpbrd_sts_t         sts,
  input  logic               in_op,
  input  logic [31:0]        in_entry_time,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  input  logic [31:0]        in_start_time,
  input  logic [31:0]        in_end_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic signed [31:0] out_delta_x,
  output logic signed [31:0] out_delta_y,
  output logic signed [15:0] out_delta_quat_z,
  output logic signed [15:0] out_delta_quat_w
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // captured beat
  logic               op_r;
  logic [31:0]        time_r, ts_r, te_r;
  logic signed [31:0] px_r, py_r;
  logic signed [15:0] qz_r, qw_r;

  // yaw extraction
  logic signed [35:0] vx_r, vy_r;
  logic               zero_q_r;
  logic signed [31:0] ww, zz, wz;
  logic signed [35:0] wz36;

  // entry store
  tpbrd_entry_t mem [DEPTH];
  tpbrd_entry_t mem_rd_r;
  tpbrd_entry_t wr_ent;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] count_r;
  logic          clr;
  logic [31:0]   yaw_rnd;

  // scan
  logic [CW-1:0] scan_idx_r;
  logic          cmp_vld_r;
  logic [AW-1:0] cmp_idx_r, start_i_r, end_i_r;
  logic          sf_r, ef_r;
  logic          scan_more;

  // relative pose
  tpbrd_entry_t       s_ent_r, e_ent_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [31:0] c_r, s_r;
  logic               flip_r;
  logic [2:0]         mul_k_r;
  logic signed [64:0] prod_r, prod_rnd;
  logic signed [34:0] term;
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [35:0] rx_r, ry_r;
  logic [15:0]        dyaw;

  // CORDIC hookup
  logic               cor_load, cor_busy;
  logic signed [35:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [33:0] cor_z0, cor_z;
  logic [31:0]        rot_a, rot_p, rot_a2;
  logic               rot_flip;
  logic signed [35:0] cx_f, cy_f;

  // output register
  logic               out_valid_r, out_found_r;
  logic [31:0]        out_dx_r, out_dy_r;
  logic [15:0]        out_qz_r, out_qw_r;

  // capture beat
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_op;
      time_r <= in_entry_time;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      qz_r   <= in_quat_z;
      qw_r   <= in_quat_w;
      ts_r   <= in_start_time;
      te_r   <= in_end_time;
    end
  end

  // heading vector: (w^2 - z^2, 2wz)
  assign ww   = qw_r * qw_r;
  assign zz   = qz_r * qz_r;
  assign wz   = qw_r * qz_r;
  assign wz36 = 36'(wz);

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      vx_r <= 36'(ww) - 36'(zz);
      vy_r <= wz36 + wz36;
    end
  end

  // rotation angle: start yaw, or half of the yaw difference
  assign dyaw     = e_ent_r.yaw - s_ent_r.yaw;
  assign rot_a    = cmd.rot2_ld ? {dyaw[15], dyaw, 15'd0} : {s_ent_r.yaw, 16'd0};
  assign rot_p    = rot_a + 32'h4000_0000;
  assign rot_flip = rot_p[31];
  assign rot_a2   = {rot_a[31] ^ rot_flip, rot_a[30:0]};

  // CORDIC load mux
  always_comb begin
    cor_load = cmd.vec_ld | cmd.rot1_ld | cmd.rot2_ld;
    if (cmd.vec_ld) begin
      cor_x0 = vx_r[35] ? -vx_r : vx_r;
      cor_y0 = vx_r[35] ? -vy_r : vy_r;
      cor_z0 = vx_r[35] ? 34'sh0_8000_0000 : 34'sd0;
    end else begin
      cor_x0 = GAIN_Q30;
      cor_y0 = 36'sd0;
      cor_z0 = {{2{rot_a2[31]}}, rot_a2};
    end
  end

  tpbrd_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cor_load),
    .vec_mode(cmd.vec_ld),
    .x0      (cor_x0),
    .y0      (cor_y0),
    .z0      (cor_z0),
    .busy    (cor_busy),
    .x       (cor_x),
    .y       (cor_y),
    .z       (cor_z)
  );

  always_ff @(posedge clk) begin
    if (cmd.vec_ld) begin
      zero_q_r <= (vx_r == 36'sd0) && (vy_r == 36'sd0);
    end
    if (cmd.rot1_ld || cmd.rot2_ld) begin
      flip_r <= rot_flip;
    end
  end

  assign cx_f = flip_r ? -cor_x : cor_x;
  assign cy_f = flip_r ? -cor_y : cor_y;

  // store write, clearing the store first once it holds more than CLEAR_LIMIT entries or is full
  assign clr     = (32'(count_r) > CLEAR_LIMIT) || (count_r >= CW'(DEPTH));
  assign wr_addr = clr ? '0 : count_r[AW-1:0];
  assign yaw_rnd = cor_z[31:0] + 32'h0000_8000;

  always_comb begin
    wr_ent.stamp = time_r;
    wr_ent.x     = px_r;
    wr_ent.y     = py_r;
    wr_ent.yaw   = zero_q_r ? 16'd0 : yaw_rnd[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr) begin
      count_r <= CW'(wr_addr) + 1'b1;
    end
  end

  // entry memory, one write and one registered read port
  assign rd_addr = cmd.rd_start ? start_i_r :
                   cmd.rd_end   ? end_i_r   : scan_idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_ent;
    end
    mem_rd_r <= mem[rd_addr];
  end

  // scan oldest to newest, last match wins
  assign scan_more = scan_idx_r < count_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      sf_r       <= 1'b0;
      ef_r       <= 1'b0;
    end else begin
      if (cmd.scan) begin
        cmp_vld_r <= scan_more;
        cmp_idx_r <= scan_idx_r[AW-1:0];
        if (scan_more) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
      if (cmp_vld_r) begin
        if (mem_rd_r.stamp == ts_r) begin
          sf_r      <= 1'b1;
          start_i_r <= cmp_idx_r;
        end
        if (mem_rd_r.stamp == te_r) begin
          ef_r    <= 1'b1;
          end_i_r <= cmp_idx_r;
        end
      end
    end
  end

  // latch start and end entries, position difference
  always_ff @(posedge clk) begin
    if (cmd.lat_start) begin
      s_ent_r <= mem_rd_r;
    end
    if (cmd.lat_end) begin
      e_ent_r <= mem_rd_r;
    end
    if (cmd.rot1_ld) begin
      dx_r <= 33'(e_ent_r.x) - 33'(s_ent_r.x);
      dy_r <= 33'(e_ent_r.y) - 33'(s_ent_r.y);
    end
    if (cmd.cs_cap) begin
      c_r <= cx_f[31:0];
      s_r <= cy_f[31:0];
    end
  end

  // shared multiplier: dx*c, dy*s, dy*c, dx*s, one per cycle
  always_comb begin
    case (mul_k_r)
      3'd0:    begin ma = dx_r; mb = c_r; end
      3'd1:    begin ma = dy_r; mb = s_r; end
      3'd2:    begin ma = dy_r; mb = c_r; end
      default: begin ma = dx_r; mb = s_r; end
    endcase
  end

  assign prod_rnd = prod_r + 65'sd536870912;
  assign term     = prod_rnd[64:30];

  always_ff @(posedge clk) begin
    if (cmd.cs_cap) begin
      mul_k_r <= '0;
    end else if (cmd.mul) begin
      mul_k_r <= mul_k_r + 1'b1;
      if (mul_k_r < 3'd4) begin
        prod_r <= ma * mb;
      end
      case (mul_k_r)
        3'd1:    rx_r <= 36'(term);
        3'd2:    rx_r <= rx_r + 36'(term);
        3'd3:    ry_r <= 36'(term);
        3'd4:    ry_r <= ry_r - 36'(term);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= sf_r && ef_r;
      if (sf_r && ef_r) begin
        out_dx_r <= sat32(rx_r);
        out_dy_r <= sat32(ry_r);
        out_qz_r <= q30_to_q14(cy_f);
        out_qw_r <= q30_to_q14(cx_f);
      end else begin
        out_dx_r <= '0;
        out_dy_r <= '0;
        out_qz_r <= '0;
        out_qw_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_delta_x      = out_dx_r;
  assign out_delta_y      = out_dy_r;
  assign out_delta_quat_z = out_qz_r;
  assign out_delta_quat_w = out_qw_r;

  // status
  always_comb begin
    sts.is_query    = op_r;
    sts.cordic_busy = cor_busy;
    sts.scan_done   = !scan_more && !cmp_vld_r;
    sts.found_both  = sf_r && ef_r;
    sts.mul_done    = (mul_k_r == 3'd5);
    sts.out_free    = !out_valid_r || !out_stall;
  end

`ifndef SYNTHESIS
  // fill count never passes the store size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");
`endif

endmodule

// ===== hw/rtl/tpbrd_ctrl.sv =====
`timescale 1ns / 1ps

module tpbrd_ctrl
  import tpbrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output tpbrd_cmd_t cmd,
  input  tpbrd_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_VLD, ST_VEC, ST_WR, ST_SCAN, ST_RDS, ST_RDE,
    ST_LATE, ST_R1LD, ST_R1, ST_MUL, ST_R2LD, ST_R2, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.cap = in_valid && !in_stall_r;
        if (cmd.cap) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = sts.is_query ? ST_SCAN : ST_VLD;
      end
      ST_VLD: begin
        cmd.vec_ld = 1'b1;
        state_nxt  = ST_VEC;
      end
      ST_VEC: begin
        if (!sts.cordic_busy) state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = sts.found_both ? ST_RDS : ST_OUT;
      end
      ST_RDS: begin
        cmd.rd_start = 1'b1;
        state_nxt    = ST_RDE;
      end
      ST_RDE: begin
        cmd.rd_end    = 1'b1;
        cmd.lat_start = 1'b1;
        state_nxt     = ST_LATE;
      end
      ST_LATE: begin
        cmd.lat_end = 1'b1;
        state_nxt   = ST_R1LD;
      end
      ST_R1LD: begin
        cmd.rot1_ld = 1'b1;
        state_nxt   = ST_R1;
      end
      ST_R1: begin
        if (!sts.cordic_busy) begin
          cmd.cs_cap = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = !sts.mul_done;
        if (sts.mul_done) state_nxt = ST_R2LD;
      end
      ST_R2LD: begin
        cmd.rot2_ld = 1'b1;
        state_nxt   = ST_R2;
      end
      ST_R2: begin
        if (!sts.cordic_busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

`ifndef SYNTHESIS
  a_cap_then_sq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> (state_r == ST_SQ))
    else $error("accepted beat did not start work");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrote a waiting beat");
  a_idle_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.cordic_busy)
    else $error("CORDIC busy while idle");
`endif

endmodule

// ===== hw/rtl/timestamped_pose_buffer_relative_delta_top.sv =====
`timescale 1ns / 1ps

// Timestamped planar pose store with relative-pose query.
// Input channel (in_valid/in_stall): in_op = 0 stores a pose (stamp, x, y,
// z-axis quaternion), in_op = 1 queries the pose at in_end_time relative to
// the pose at in_start_time. A store gives no result beat; a query gives one.
// Result channel (out_valid/out_stall): found flag, relative x/y in the
// start frame (Q16.16, saturated) and the yaw difference as quaternion z/w.
// Store: the time from one accepted beat to the next is set by the shared
// iterative CORDIC.
// Query: the time until the result is valid is set by the scan of the stored
// entries, one entry per cycle through the memory read port, plus two CORDIC
// runs and four passes through the shared multiplier; when a stamp is missing
// the CORDIC runs and the multiplier are skipped. One beat is in work at a
// time; in_stall is high while it is.
// Reset (rst_n low, synchronous) empties the store; no clearing pass.
// A result waits in the output register while out_stall is high; the next
// beat is still accepted and a later query result waits for the register.
module timestamped_pose_buffer_relative_delta_top
  import tpbrd_pkg::*;
#(
  parameter int DEPTH        = 512,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [31:0]        in_entry_time,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  input  logic [31:0]        in_start_time,
  input  logic [31:0]        in_end_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic signed [31:0] out_delta_x,
  output logic signed [31:0] out_delta_y,
  output logic signed [15:0] out_delta_quat_z,
  output logic signed [15:0] out_delta_quat_w
);

  tpbrd_cmd_t cmd;
  tpbrd_sts_t sts;

  tpbrd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  tpbrd_dp #(
    .DEPTH       (DEPTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_entry_time   (in_entry_time),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_quat_z       (in_quat_z),
    .in_quat_w       (in_quat_w),
    .in_start_time   (in_start_time),
    .in_end_time     (in_end_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_delta_quat_z(out_delta_quat_z),
    .out_delta_quat_w(out_delta_quat_w)
  );

endmodule
